// ===== rtl/core/rgbws_pkg.sv =====
// Shared types, constants and the per-channel smoothing arithmetic.
`default_nettype none

package rgbws_pkg;

    localparam int CHAN_W       = 8;
    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 13;
    localparam int ROW_W        = 12;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int CMP_W        = 14;

    localparam logic [CMP_W-1:0]        MIN_DIM    = 14'd3;
    localparam logic [IMG_HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;

    localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd768;

    // Register indexes of the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Reciprocal of 6 in 14 fractional bits; exact for sums up to 1527.
    localparam logic [11:0] RECIP_SIX = 12'd2731;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    localparam int PIX_W = $bits(pix_t);

    typedef struct packed {
        logic emit;
        logic frame_end;
    } raster_t;

    // Three quarters of a channel value, truncated.
    function automatic logic [CHAN_W-1:0] three_quarters(input logic [CHAN_W-1:0] v);
        logic [CHAN_W+1:0] t;
        t = {1'b0, v, 1'b0} + {2'b00, v};
        return t[CHAN_W+1:2];
    endfunction

    // Weighted 3x3 sum of one channel divided by six; a..i in raster order.
    function automatic logic [CHAN_W-1:0] smooth_chan(
        input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] d, input logic [CHAN_W-1:0] e, input logic [CHAN_W-1:0] f,
        input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] h, input logic [CHAN_W-1:0] i
    );
        logic [10:0] sum;
        logic [22:0] prod;
        sum = 11'(a >> 1) + 11'(c >> 1) + 11'(g >> 1) + 11'(i >> 1)
            + 11'(three_quarters(b)) + 11'(three_quarters(d))
            + 11'(three_quarters(f)) + 11'(three_quarters(h))
            + 11'(e);
        prod = 23'(sum) * 23'(RECIP_SIX);
        return prod[21:14];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgbws_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rgbws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rgbws_raster.sv =====
// Column and row counters that place each incoming pixel in the frame.
`default_nettype none

module rgbws_raster #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 advance,
    input  wire logic [rgbws_pkg::IMG_WIDTH_W-1:0]    image_width,
    input  wire logic [rgbws_pkg::IMG_HEIGHT_W-1:0]   image_height,
    output logic      [AW-1:0]                        col,
    output rgbws_pkg::raster_t                        pos
);

    import rgbws_pkg::*;

    localparam logic [CMP_W-1:0] MAX_W_CMP = CMP_W'(MAX_WIDTH);

    logic [AW-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [CMP_W-1:0]        width_eff;
    logic [IMG_HEIGHT_W-1:0] height_eff;
    logic                    last_col;
    logic                    last_row;

    always_comb begin
        if (CMP_W'(image_width) < MIN_DIM) begin
            width_eff = MIN_DIM;
        end else if (CMP_W'(image_width) > MAX_W_CMP) begin
            width_eff = MAX_W_CMP;
        end else begin
            width_eff = CMP_W'(image_width);
        end

        if (image_height < IMG_HEIGHT_W'(MIN_DIM)) begin
            height_eff = IMG_HEIGHT_W'(MIN_DIM);
        end else if (image_height > MAX_HEIGHT) begin
            height_eff = MAX_HEIGHT;
        end else begin
            height_eff = image_height;
        end
    end

    // A counter already past the end after a size change wraps as well.
    assign last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= width_eff;
    assign last_row = (IMG_HEIGHT_W'(row_reg) + IMG_HEIGHT_W'(1)) >= height_eff;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col           = col_reg;
    assign pos.emit      = (col_reg >= AW'(2)) && (row_reg >= ROW_W'(2));
    assign pos.frame_end = last_col && last_row;

endmodule

`default_nettype wire

// ===== rtl/core/rgbws_window.sv =====
// Six-entry pixel window and the weighted smoothing of its 3x3 neighborhood.
`default_nettype none

module rgbws_window (
    input  wire logic            aclk,
    input  wire logic            shift_en,
    input  wire rgbws_pkg::pix_t top,
    input  wire rgbws_pkg::pix_t mid,
    input  wire rgbws_pkg::pix_t bot,
    output rgbws_pkg::pix_t      result
);

    import rgbws_pkg::*;

    // Entries 0..2 hold the column two back, 3..5 the previous column.
    pix_t win_reg [6];

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot;
        end
    end

    assign result.red = smooth_chan(
        win_reg[0].red, win_reg[3].red, top.red,
        win_reg[1].red, win_reg[4].red, mid.red,
        win_reg[2].red, win_reg[5].red, bot.red);

    assign result.green = smooth_chan(
        win_reg[0].green, win_reg[3].green, top.green,
        win_reg[1].green, win_reg[4].green, mid.green,
        win_reg[2].green, win_reg[5].green, bot.green);

    assign result.blue = smooth_chan(
        win_reg[0].blue, win_reg[3].blue, top.blue,
        win_reg[1].blue, win_reg[4].blue, mid.blue,
        win_reg[2].blue, win_reg[5].blue, bot.blue);

endmodule

`default_nettype wire

// ===== rtl/core/rgb_3x3_weighted_smooth.sv =====
// Streaming 3x3 weighted smoothing filter for RGB pixels in raster order.
//
// Pixels enter on the s_ stream one per request, line by line. Two line
// buffers in block RAM and a six-entry window form the 3x3 neighborhood whose
// center lies one line up and one column left of the newest pixel. Only
// interior pixels produce a result on the m_ stream; m_tlast marks the last
// interior pixel of the frame. Border pixels are consumed silently.
// An accepted pixel passes the read stage and then the output register
// before its result shows on m_tdata. One pixel is taken every cycle while
// the receiver does not stall; the line-buffer read is registered, so the
// read of the next pixel overlaps the write-back and filtering of the current one.
// When the receiver stalls, the result waits in the output register and one
// more pixel can sit in the read stage; after that s_tready drops.
// Reset clears the counters and empties the pipeline; width returns to 1024
// and height to 768. Line buffer contents are not cleared, since the first
// two lines of a frame refill them before any result uses them.
// Configuration writes on cfg_ are always taken and must be made while the
// block is idle.
`default_nettype none

module rgb_3x3_weighted_smooth #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // pix_red [7:0], pix_green [15:8], pix_blue [23:16]
    input  wire logic [rgbws_pkg::PIX_W-1:0]          s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic      [rgbws_pkg::PIX_W-1:0]          m_tdata,
    output logic                                      m_tlast,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rgbws_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rgbws_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import rgbws_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;

    logic          s_accept;
    logic          b_adv;
    logic          out_load;
    logic          b_valid_reg, b_valid_next;
    logic          m_valid_reg, m_valid_next;
    pix_t          bot_reg;
    logic [AW-1:0] addr_reg;
    raster_t       pos_reg;
    pix_t          out_pix_reg;
    logic          out_last_reg;

    logic [AW-1:0] col;
    raster_t       pos;
    pix_t          in_pix;
    pix_t          top_line;
    pix_t          mid_line;
    pix_t          result;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_data[IMG_WIDTH_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: stage B holds a pixel whose line-buffer read is in flight.
    assign b_adv    = b_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !b_valid_reg || b_adv;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = b_adv && pos_reg.emit;

    assign in_pix.red   = s_tdata[CHAN_W-1:0];
    assign in_pix.green = s_tdata[2*CHAN_W-1:CHAN_W];
    assign in_pix.blue  = s_tdata[3*CHAN_W-1:2*CHAN_W];

    rgbws_raster #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_raster (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (s_accept),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col          (col),
        .pos          (pos)
    );

    // The older line moves up as the pixel's column is written back.
    rgbws_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_top_line (
        .aclk    (aclk),
        .wr_en   (b_adv),
        .wr_addr (addr_reg),
        .wr_data (mid_line),
        .rd_en   (s_accept),
        .rd_addr (col),
        .rd_data (top_line)
    );

    rgbws_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_mid_line (
        .aclk    (aclk),
        .wr_en   (b_adv),
        .wr_addr (addr_reg),
        .wr_data (bot_reg),
        .rd_en   (s_accept),
        .rd_addr (col),
        .rd_data (mid_line)
    );

    rgbws_window u_window (
        .aclk     (aclk),
        .shift_en (b_adv),
        .top      (top_line),
        .mid      (mid_line),
        .bot      (bot_reg),
        .result   (result)
    );

    always_comb begin
        b_valid_next = b_valid_reg;
        if (s_accept) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            bot_reg  <= in_pix;
            addr_reg <= col;
            pos_reg  <= pos;
        end
        if (out_load) begin
            out_pix_reg  <= result;
            out_last_reg <= pos_reg.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_pix_reg.blue, out_pix_reg.green, out_pix_reg.red};
    assign m_tlast  = out_last_reg;

    // A pixel taken in always occupies the read stage on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> b_valid_reg)
        else $error("accepted pixel did not reach the read stage");

    // While the read stage is stalled, the line-buffer read data must hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_adv) |=> (b_valid_reg && $stable(top_line) && $stable(mid_line)))
        else $error("line buffer data changed under a stalled pixel");

    // An interior pixel leaving the read stage must show up as a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("interior pixel produced no result");

endmodule

`default_nettype wire
